### hw/rtl/cor_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cor_pkg
// Shared types, widths and helpers for the collision overlap resolver.
// ----------------------------------------------------------------------------
package cor_pkg;

   localparam int COORD_W    = 24;
   localparam int DIM_W      = 23;
   localparam int MODE_W     = 2;
   localparam int THR_W      = 32;
   localparam int BOX_W      = 29;
   localparam int CDIFF_W    = 25;
   localparam int RR_W       = 24;
   localparam int MTV_W      = 28;
   localparam int SQ_W       = 50;
   localparam int SQRT_STAGES = SQ_W / 2;
   localparam int ROOT_W     = 25;
   localparam int SREM_W     = 28;
   localparam int OV_W       = 26;
   localparam int PROD_W     = 51;
   localparam int MAG_W      = 52;
   localparam int QUO_W      = 27;
   localparam int DREM_W     = MAG_W - QUO_W;
   localparam int SQR_W      = 2 * MTV_W;
   localparam int DISP_W     = 30;
   localparam int BACK_STAGES = 1 + SQRT_STAGES + 3 + QUO_W + 2;
   localparam int FIFO_DEPTH = 2;
   localparam int FIFO_PTR_W = 1;
   localparam int FIFO_CNT_W = 2;

   localparam logic [THR_W-1:0] MIN_MOVE_SQ_RESET = 32'd256;

   localparam logic [MODE_W-1:0] MODE_BOX_BOX   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_CIRC_CIRC = 2'd1;
   localparam logic [MODE_W-1:0] MODE_BOX_CIRC  = 2'd2;
   localparam logic [MODE_W-1:0] MODE_CIRC_BOX  = 2'd3;

   typedef struct packed {
      logic [MODE_W-1:0]         mode;
      logic signed [COORD_W-1:0] a_x;
      logic signed [COORD_W-1:0] a_y;
      logic [DIM_W-1:0]          a_w;
      logic [DIM_W-1:0]          a_h;
      logic signed [COORD_W-1:0] b_x;
      logic signed [COORD_W-1:0] b_y;
      logic [DIM_W-1:0]          b_w;
      logic [DIM_W-1:0]          b_h;
      logic                      push_a;
      logic                      push_b;
   } req_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] a_dx;
      logic signed [COORD_W-1:0] a_dy;
      logic signed [COORD_W-1:0] b_dx;
      logic signed [COORD_W-1:0] b_dy;
      logic                      ignored;
   } rsp_type;

   // one classified pair waiting for the back end
   typedef struct packed {
      logic                      circ;
      logic                      negate;
      logic                      push_a;
      logic                      push_b;
      logic signed [MTV_W-1:0]   mx;
      logic signed [MTV_W-1:0]   my;
      logic signed [CDIFF_W-1:0] cdx;
      logic signed [CDIFF_W-1:0] cdy;
      logic [RR_W-1:0]           rr;
      logic [SQ_W-1:0]           d2;
   } work_type;

   // back end pipeline word
   typedef struct packed {
      work_type                  wk;
      logic                      zero;
      logic [ROOT_W-1:0]         root;
      logic [SREM_W-1:0]         srem;
      logic signed [OV_W-1:0]    ovv;
      logic signed [PROD_W-1:0]  px;
      logic signed [PROD_W-1:0]  py;
      logic                      sgn_x;
      logic                      sgn_y;
      logic [MAG_W-1:0]          magx;
      logic [MAG_W-1:0]          magy;
      logic [QUO_W-1:0]          qx;
      logic [QUO_W-1:0]          qy;
      logic [DREM_W-1:0]         rx;
      logic [DREM_W-1:0]         ry;
      logic [SQR_W-1:0]          mxx;
      logic [SQR_W-1:0]          myy;
   } bk_type;

   function automatic logic signed [BOX_W-1:0] sext_box(logic [COORD_W-1:0] v);
      return $signed({{(BOX_W-COORD_W){v[COORD_W-1]}}, v});
   endfunction

   function automatic logic signed [BOX_W-1:0] zext_box(logic [DIM_W-1:0] v);
      return $signed({{(BOX_W-DIM_W){1'b0}}, v});
   endfunction

   function automatic logic signed [COORD_W-1:0] sat24(logic signed [DISP_W-1:0] v);
      logic signed [COORD_W-1:0] r;
      if (v > 30'sd8388607) begin
         r = 24'sh7FFFFF;
      end else if (v < -30'sd8388608) begin
         r = 24'sh800000;
      end else begin
         r = v[COORD_W-1:0];
      end
      return r;
   endfunction

endpackage

### hw/rtl/cor_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cor_front
// Accepts pairs, forms box overlaps and mtv, and circle offsets and squared
// distance; two register stages.
// ----------------------------------------------------------------------------
module cor_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  cor_pkg::req_type  req_data,
   input  logic              q_full,
   output logic              q_push,
   output cor_pkg::work_type q_data
);

   typedef struct packed {
      logic                              circ;
      logic                              negate;
      logic                              push_a;
      logic                              push_b;
      logic signed [cor_pkg::BOX_W-1:0]  dx;
      logic signed [cor_pkg::BOX_W-1:0]  dy;
      logic signed [cor_pkg::BOX_W-1:0]  sx;
      logic signed [cor_pkg::BOX_W-1:0]  sy;
      logic signed [cor_pkg::CDIFF_W-1:0] cdx;
      logic signed [cor_pkg::CDIFF_W-1:0] cdy;
      logic [cor_pkg::RR_W-1:0]          rr;
   } f1_type;

   logic   adv;
   logic   f1_valid_ff, f2_valid_ff;
   f1_type f1_ff, f1_in;
   cor_pkg::work_type f2_ff, f2_in;

   logic signed [cor_pkg::BOX_W-1:0] ax, ay, bx, by, aw, ah, bw, bh;
   logic signed [cor_pkg::BOX_W-1:0] adx, ady, o2x, o2y, hx, hy;
   logic signed [2*cor_pkg::CDIFF_W-1:0] sqx, sqy;

   assign adv       = !f2_valid_ff || !q_full;
   assign req_ready = adv;
   assign q_push    = f2_valid_ff && !q_full;
   assign q_data    = f2_ff;

   always_comb begin
      ax = cor_pkg::sext_box(req_data.a_x);
      ay = cor_pkg::sext_box(req_data.a_y);
      bx = cor_pkg::sext_box(req_data.b_x);
      by = cor_pkg::sext_box(req_data.b_y);
      aw = cor_pkg::zext_box(req_data.a_w);
      ah = cor_pkg::zext_box(req_data.a_h);
      bw = cor_pkg::zext_box(req_data.b_w);
      bh = cor_pkg::zext_box(req_data.b_h);
      f1_in.circ   = (req_data.mode == cor_pkg::MODE_CIRC_CIRC);
      f1_in.negate = (req_data.mode == cor_pkg::MODE_CIRC_BOX);
      f1_in.push_a = req_data.push_a;
      f1_in.push_b = req_data.push_b;
      // box centres at twice their value
      case (req_data.mode)
         cor_pkg::MODE_BOX_CIRC: begin
            f1_in.dx = (ax <<< 1) + aw - (bx <<< 1);
            f1_in.dy = (ay <<< 1) + ah - (by <<< 1);
            f1_in.sx = aw + (bw <<< 1);
            f1_in.sy = ah + (bw <<< 1);
         end
         cor_pkg::MODE_CIRC_BOX: begin
            f1_in.dx = (bx <<< 1) + bw - (ax <<< 1);
            f1_in.dy = (by <<< 1) + bh - (ay <<< 1);
            f1_in.sx = bw + (aw <<< 1);
            f1_in.sy = bh + (aw <<< 1);
         end
         default: begin
            f1_in.dx = (ax <<< 1) + aw - ((bx <<< 1) + bw);
            f1_in.dy = (ay <<< 1) + ah - ((by <<< 1) + bh);
            f1_in.sx = aw + bw;
            f1_in.sy = ah + bh;
         end
      endcase
      f1_in.cdx = $signed({req_data.a_x[cor_pkg::COORD_W-1], req_data.a_x})
                - $signed({req_data.b_x[cor_pkg::COORD_W-1], req_data.b_x});
      f1_in.cdy = $signed({req_data.a_y[cor_pkg::COORD_W-1], req_data.a_y})
                - $signed({req_data.b_y[cor_pkg::COORD_W-1], req_data.b_y});
      f1_in.rr  = {1'b0, req_data.a_w} + {1'b0, req_data.b_w};
   end

   always_comb begin
      adx = (f1_ff.dx < 0) ? -f1_ff.dx : f1_ff.dx;
      ady = (f1_ff.dy < 0) ? -f1_ff.dy : f1_ff.dy;
      o2x = f1_ff.sx - adx;
      o2y = f1_ff.sy - ady;
      hx  = (f1_ff.dx < 0) ? -o2x : o2x;
      hy  = (f1_ff.dy < 0) ? -o2y : o2y;
      sqx = f1_ff.cdx * f1_ff.cdx;
      sqy = f1_ff.cdy * f1_ff.cdy;
      f2_in.circ   = f1_ff.circ;
      f2_in.negate = f1_ff.negate;
      f2_in.push_a = f1_ff.push_a;
      f2_in.push_b = f1_ff.push_b;
      // doubled overlaps are even, so the halving is exact; ties go to y
      if (o2x < o2y) begin
         f2_in.mx = hx[cor_pkg::MTV_W:1];
         f2_in.my = '0;
      end else begin
         f2_in.mx = '0;
         f2_in.my = hy[cor_pkg::MTV_W:1];
      end
      f2_in.cdx = f1_ff.cdx;
      f2_in.cdy = f1_ff.cdy;
      f2_in.rr  = f1_ff.rr;
      f2_in.d2  = $unsigned(sqx) + $unsigned(sqy);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
         f2_valid_ff <= 1'b0;
      end else if (adv) begin
         f1_valid_ff <= req_valid;
         f2_valid_ff <= f1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         f1_ff <= f1_in;
         f2_ff <= f2_in;
      end
   end

endmodule

### hw/rtl/cor_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cor_fifo
// Short queue between the front end and the back end.
// ----------------------------------------------------------------------------
module cor_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  cor_pkg::work_type push_data,
   output logic              full,
   input  logic              pop,
   output logic              not_empty,
   output cor_pkg::work_type pop_data
);

   cor_pkg::work_type mem [cor_pkg::FIFO_DEPTH];
   logic [cor_pkg::FIFO_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [cor_pkg::FIFO_CNT_W-1:0] cnt_ff, cnt_in;

   assign full      = (cnt_ff == cor_pkg::FIFO_CNT_W'(cor_pkg::FIFO_DEPTH));
   assign not_empty = (cnt_ff != '0);
   assign pop_data  = mem[rd_ptr_ff];

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### hw/rtl/cor_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cor_back
// Pipelined square root and dividers for circle pairs, threshold test,
// push gating and saturation into the result register.
// ----------------------------------------------------------------------------
module cor_back (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      wk_valid,
   input  cor_pkg::work_type         wk_data,
   output logic                      wk_pop,
   input  logic [cor_pkg::THR_W-1:0] min_move_sq,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output cor_pkg::rsp_type          rsp_data
);

   logic adv;
   logic [cor_pkg::BACK_STAGES-1:0] vld_ff;
   logic rsp_valid_ff;
   cor_pkg::rsp_type rsp_ff, rsp_in;

   cor_pkg::bk_type ld_ff, ld_in;
   cor_pkg::bk_type sq_ff  [cor_pkg::SQRT_STAGES];
   cor_pkg::bk_type sq_in  [cor_pkg::SQRT_STAGES];
   cor_pkg::bk_type sq_src [cor_pkg::SQRT_STAGES+1];
   cor_pkg::bk_type ov_ff, ov_in, mul_ff, mul_in, prep_ff, prep_in;
   cor_pkg::bk_type dv_ff  [cor_pkg::QUO_W];
   cor_pkg::bk_type dv_in  [cor_pkg::QUO_W];
   cor_pkg::bk_type dv_src [cor_pkg::QUO_W+1];
   cor_pkg::bk_type sel_ff, sel_in, sqr_ff, sqr_in;

   logic [cor_pkg::PROD_W-1:0]     absx, absy;
   logic [cor_pkg::SQR_W-1:0]      lsq;
   logic signed [cor_pkg::SQR_W-1:0] mxx_w, myy_w;
   logic signed [cor_pkg::DISP_W-1:0] ad_x, ad_y, bd_x, bd_y;

   assign adv       = !rsp_valid_ff || rsp_ready;
   assign wk_pop    = adv && wk_valid;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      ld_in      = '0;
      ld_in.wk   = wk_data;
      ld_in.zero = (wk_data.d2 == '0);
   end

   assign sq_src[0] = ld_ff;

   // restoring square root, two radicand bits per stage
   for (genvar k = 0; k < cor_pkg::SQRT_STAGES; k++) begin : g_sqrt
      logic [cor_pkg::SREM_W-1:0] rem_sh, trial;
      always_comb begin
         sq_in[k] = sq_src[k];
         rem_sh   = {sq_src[k].srem[cor_pkg::SREM_W-3:0],
                     sq_src[k].wk.d2[cor_pkg::SQ_W-1-2*k -: 2]};
         trial    = {1'b0, sq_src[k].root, 2'b01};
         if (rem_sh >= trial) begin
            sq_in[k].srem = rem_sh - trial;
            sq_in[k].root = {sq_src[k].root[cor_pkg::ROOT_W-2:0], 1'b1};
         end else begin
            sq_in[k].srem = rem_sh;
            sq_in[k].root = {sq_src[k].root[cor_pkg::ROOT_W-2:0], 1'b0};
         end
      end
      assign sq_src[k+1] = sq_ff[k];
   end

   always_comb begin
      ov_in     = sq_src[cor_pkg::SQRT_STAGES];
      ov_in.ovv = $signed({2'b00, ov_in.wk.rr}) - $signed({1'b0, ov_in.root});
   end

   always_comb begin
      mul_in    = ov_ff;
      mul_in.px = ov_ff.wk.cdx * ov_ff.ovv;
      mul_in.py = ov_ff.wk.cdy * ov_ff.ovv;
   end

   // rounding: add half the divisor to the magnitude
   always_comb begin
      prep_in       = mul_ff;
      absx          = mul_ff.px[cor_pkg::PROD_W-1] ? $unsigned(-mul_ff.px)
                                                  : $unsigned(mul_ff.px);
      absy          = mul_ff.py[cor_pkg::PROD_W-1] ? $unsigned(-mul_ff.py)
                                                  : $unsigned(mul_ff.py);
      prep_in.sgn_x = mul_ff.px[cor_pkg::PROD_W-1];
      prep_in.sgn_y = mul_ff.py[cor_pkg::PROD_W-1];
      prep_in.magx  = cor_pkg::MAG_W'(absx)
                    + cor_pkg::MAG_W'(mul_ff.root[cor_pkg::ROOT_W-1:1]);
      prep_in.magy  = cor_pkg::MAG_W'(absy)
                    + cor_pkg::MAG_W'(mul_ff.root[cor_pkg::ROOT_W-1:1]);
      prep_in.rx    = prep_in.magx[cor_pkg::MAG_W-1:cor_pkg::QUO_W];
      prep_in.ry    = prep_in.magy[cor_pkg::MAG_W-1:cor_pkg::QUO_W];
      prep_in.qx    = '0;
      prep_in.qy    = '0;
   end

   assign dv_src[0] = prep_ff;

   // restoring dividers for both components, one quotient bit per stage
   for (genvar j = 0; j < cor_pkg::QUO_W; j++) begin : g_div
      logic [cor_pkg::DREM_W:0] rsx, rsy, den;
      always_comb begin
         dv_in[j] = dv_src[j];
         den      = {1'b0, dv_src[j].root};
         rsx      = {dv_src[j].rx, dv_src[j].magx[cor_pkg::QUO_W-1-j]};
         rsy      = {dv_src[j].ry, dv_src[j].magy[cor_pkg::QUO_W-1-j]};
         if (rsx >= den) begin
            dv_in[j].rx = cor_pkg::DREM_W'(rsx - den);
            dv_in[j].qx = {dv_src[j].qx[cor_pkg::QUO_W-2:0], 1'b1};
         end else begin
            dv_in[j].rx = rsx[cor_pkg::DREM_W-1:0];
            dv_in[j].qx = {dv_src[j].qx[cor_pkg::QUO_W-2:0], 1'b0};
         end
         if (rsy >= den) begin
            dv_in[j].ry = cor_pkg::DREM_W'(rsy - den);
            dv_in[j].qy = {dv_src[j].qy[cor_pkg::QUO_W-2:0], 1'b1};
         end else begin
            dv_in[j].ry = rsy[cor_pkg::DREM_W-1:0];
            dv_in[j].qy = {dv_src[j].qy[cor_pkg::QUO_W-2:0], 1'b0};
         end
      end
      assign dv_src[j+1] = dv_ff[j];
   end

   always_comb begin
      sel_in = dv_src[cor_pkg::QUO_W];
      if (sel_in.wk.circ) begin
         // coincident centres give no move
         if (sel_in.zero) begin
            sel_in.wk.mx = '0;
            sel_in.wk.my = '0;
         end else begin
            sel_in.wk.mx = sel_in.sgn_x ? -$signed({1'b0, sel_in.qx})
                                        : $signed({1'b0, sel_in.qx});
            sel_in.wk.my = sel_in.sgn_y ? -$signed({1'b0, sel_in.qy})
                                        : $signed({1'b0, sel_in.qy});
         end
      end
   end

   always_comb begin
      sqr_in     = sel_ff;
      mxx_w      = sel_ff.wk.mx * sel_ff.wk.mx;
      myy_w      = sel_ff.wk.my * sel_ff.wk.my;
      sqr_in.mxx = $unsigned(mxx_w);
      sqr_in.myy = $unsigned(myy_w);
   end

   always_comb begin
      lsq  = sqr_ff.mxx + sqr_ff.myy;
      ad_x = cor_pkg::DISP_W'(sqr_ff.wk.mx);
      ad_y = cor_pkg::DISP_W'(sqr_ff.wk.my);
      if (sqr_ff.wk.negate) begin
         ad_x = -ad_x;
         ad_y = -ad_y;
      end
      bd_x = -ad_x;
      bd_y = -ad_y;
      rsp_in = '0;
      if (lsq < cor_pkg::SQR_W'(min_move_sq)) begin
         rsp_in.ignored = 1'b1;
      end else begin
         if (sqr_ff.wk.push_a) begin
            rsp_in.a_dx = cor_pkg::sat24(ad_x);
            rsp_in.a_dy = cor_pkg::sat24(ad_y);
         end
         if (sqr_ff.wk.push_b) begin
            rsp_in.b_dx = cor_pkg::sat24(bd_x);
            rsp_in.b_dy = cor_pkg::sat24(bd_y);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         vld_ff       <= {vld_ff[cor_pkg::BACK_STAGES-2:0], wk_valid};
         rsp_valid_ff <= vld_ff[cor_pkg::BACK_STAGES-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ld_ff   <= ld_in;
         ov_ff   <= ov_in;
         mul_ff  <= mul_in;
         prep_ff <= prep_in;
         sel_ff  <= sel_in;
         sqr_ff  <= sqr_in;
         rsp_ff  <= rsp_in;
         for (int k = 0; k < cor_pkg::SQRT_STAGES; k++) begin
            sq_ff[k] <= sq_in[k];
         end
         for (int j = 0; j < cor_pkg::QUO_W; j++) begin
            dv_ff[j] <= dv_in[j];
         end
      end
   end

endmodule

### hw/rtl/collision_overlap_resolver_unit.sv
`timescale 1ns / 1ps
// path: front registers f1 and f2, the queue, 58 back stages, result register
// throughput: one pair per cycle while rsp_ready does not stall the result, set
// by the fully pipelined square root (one stage per root bit) and dividers (one
// stage per quotient bit)
// reset: synchronous; empties all stages and the queue, min_move_sq -> 256
// ----------------------------------------------------------------------------
// collision_overlap_resolver_unit
// Minimum translation vector for box and circle pairs with push gating.
// ----------------------------------------------------------------------------
module collision_overlap_resolver_unit (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  cor_pkg::req_type          req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output cor_pkg::rsp_type          rsp_data,
   input  logic                      csr_wr_en,
   input  logic [cor_pkg::THR_W-1:0] csr_wr_data
);

   logic [cor_pkg::THR_W-1:0] min_move_sq_ff;
   logic q_full, q_push, q_pop, q_not_empty;
   cor_pkg::work_type q_wdata, q_rdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_move_sq_ff <= cor_pkg::MIN_MOVE_SQ_RESET;
      end else if (csr_wr_en) begin
         min_move_sq_ff <= csr_wr_data;
      end
   end

   cor_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_data    (q_wdata)
   );

   cor_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wdata),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .pop_data  (q_rdata)
   );

   cor_back u_back (
      .clock       (clock),
      .reset       (reset),
      .wk_valid    (q_not_empty),
      .wk_data     (q_rdata),
      .wk_pop      (q_pop),
      .min_move_sq (min_move_sq_ff),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

endmodule

### test/collision_overlap_resolver_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// collision_overlap_resolver_unit_test
// Streams box and circle pairs through the resolver under random idling on
// both channels, predicts each displacement result and compares in order.
// ----------------------------------------------------------------------------
module collision_overlap_resolver_unit_test;

   localparam int LATENCY = 70;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_ready;
   cor_pkg::req_type          req_data;
   logic                      rsp_valid;
   logic                      rsp_ready;
   cor_pkg::rsp_type          rsp_data;
   logic                      csr_wr_en;
   logic [cor_pkg::THR_W-1:0] csr_wr_data;

   cor_pkg::req_type          pending_pairs[$];
   cor_pkg::rsp_type          expected_moves[$];
   logic [cor_pkg::THR_W-1:0] move_threshold;
   int                        send_idle_pct;
   int                        recv_stall_pct;
   bit                        hold_sender;
   int                        failures;

   collision_overlap_resolver_unit uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic longint isqrt(longint unsigned n);
      longint unsigned res;
      longint unsigned bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (n >= res + bitv) begin
            n = n - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return longint'(res);
   endfunction

   function automatic longint mag(longint v);
      return v < 0 ? -v : v;
   endfunction

   function automatic longint div_nearest(longint num, longint den);
      longint q;
      q = (mag(num) + den / 2) / den;
      return num < 0 ? -q : q;
   endfunction

   function automatic logic [cor_pkg::COORD_W-1:0] clamp24(longint v);
      if (v > 8388607) v = 8388607;
      if (v < -8388608) v = -8388608;
      return v[cor_pkg::COORD_W-1:0];
   endfunction

   // smaller-overlap axis, inputs in doubled units
   function automatic void pick_axis(longint dx, longint dy, longint ox, longint oy,
                                     output longint mx, output longint my);
      if (ox < oy) begin
         mx = (dx < 0 ? -ox : ox) / 2;
         my = 0;
      end else begin
         mx = 0;
         my = (dy < 0 ? -oy : oy) / 2;
      end
   endfunction

   function automatic cor_pkg::rsp_type predict_move(cor_pkg::req_type p,
                                                     logic [cor_pkg::THR_W-1:0] thr);
      longint ax, ay, aw, ah, bx, by, bw, bh, dx, dy, mx, my, root_len, ov, sx, sy;
      longint unsigned d2, lsq;
      bit neg;
      cor_pkg::rsp_type r;
      ax = longint'(p.a_x); ay = longint'(p.a_y);
      bx = longint'(p.b_x); by = longint'(p.b_y);
      aw = longint'({1'b0, p.a_w}); ah = longint'({1'b0, p.a_h});
      bw = longint'({1'b0, p.b_w}); bh = longint'({1'b0, p.b_h});
      mx = 0; my = 0; neg = 0;
      case (p.mode)
         cor_pkg::MODE_BOX_BOX: begin
            dx = (2 * ax + aw) - (2 * bx + bw);
            dy = (2 * ay + ah) - (2 * by + bh);
            pick_axis(dx, dy, aw + bw - mag(dx), ah + bh - mag(dy), mx, my);
         end
         cor_pkg::MODE_CIRC_CIRC: begin
            dx = ax - bx;
            dy = ay - by;
            d2 = dx * dx + dy * dy;
            if (d2 != 0) begin
               root_len = isqrt(d2);
               ov = aw + bw - root_len;
               mx = div_nearest(dx * ov, root_len);
               my = div_nearest(dy * ov, root_len);
            end
         end
         cor_pkg::MODE_BOX_CIRC: begin
            dx = (2 * ax + aw) - 2 * bx;
            dy = (2 * ay + ah) - 2 * by;
            pick_axis(dx, dy, aw + 2 * bw - mag(dx), ah + 2 * bw - mag(dy), mx, my);
         end
         default: begin
            dx = (2 * bx + bw) - 2 * ax;
            dy = (2 * by + bh) - 2 * ay;
            pick_axis(dx, dy, bw + 2 * aw - mag(dx), bh + 2 * aw - mag(dy), mx, my);
            neg = 1;
         end
      endcase
      r = '0;
      lsq = mx * mx + my * my;
      if (lsq < longint'({32'd0, thr})) begin
         r.ignored = 1'b1;
      end else begin
         sx = neg ? -mx : mx;
         sy = neg ? -my : my;
         if (p.push_a) begin
            r.a_dx = clamp24(sx);
            r.a_dy = clamp24(sy);
         end
         if (p.push_b) begin
            r.b_dx = clamp24(-sx);
            r.b_dy = clamp24(-sy);
         end
      end
      return r;
   endfunction

   function automatic cor_pkg::req_type random_pair(int spread);
      cor_pkg::req_type p;
      p = '0;
      p.mode = cor_pkg::MODE_W'($urandom_range(0, 3));
      p.push_a = 1'($urandom_range(0, 1));
      p.push_b = 1'($urandom_range(0, 1));
      if (spread == 0) begin
         p.a_x = cor_pkg::COORD_W'($urandom); p.a_y = cor_pkg::COORD_W'($urandom);
         p.b_x = cor_pkg::COORD_W'($urandom); p.b_y = cor_pkg::COORD_W'($urandom);
         p.a_w = cor_pkg::DIM_W'($urandom); p.a_h = cor_pkg::DIM_W'($urandom);
         p.b_w = cor_pkg::DIM_W'($urandom); p.b_h = cor_pkg::DIM_W'($urandom);
      end else begin
         // nearby shapes so most pairs really overlap
         p.a_x = cor_pkg::COORD_W'($signed($urandom_range(0, 2 * spread)) - spread);
         p.a_y = cor_pkg::COORD_W'($signed($urandom_range(0, 2 * spread)) - spread);
         p.b_x = p.a_x
               + cor_pkg::COORD_W'($signed($urandom_range(0, 2 * spread)) - spread);
         p.b_y = p.a_y
               + cor_pkg::COORD_W'($signed($urandom_range(0, 2 * spread)) - spread);
         p.a_w = cor_pkg::DIM_W'($urandom_range(0, 2 * spread));
         p.a_h = cor_pkg::DIM_W'($urandom_range(0, 2 * spread));
         p.b_w = cor_pkg::DIM_W'($urandom_range(0, 2 * spread));
         p.b_h = cor_pkg::DIM_W'($urandom_range(0, 2 * spread));
      end
      return p;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (pending_pairs.size() != 0 && !hold_sender &&
             $urandom_range(0, 99) >= send_idle_pct) begin
            req_data  <= pending_pairs[0];
            req_valid <= 1'b1;
            expected_moves.push_back(predict_move(pending_pairs[0], move_threshold));
            void'(pending_pairs.pop_front());
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_moves.size() == 0) begin
               $display("%0t: unexpected transaction %h", $time, rsp_data);
               failures++;
            end else begin
               if (rsp_data !== expected_moves[0]) begin
                  $display("%0t: mismatch expected a_dx %0d a_dy %0d b_dx %0d b_dy %0d ign %0b",
                           $time, expected_moves[0].a_dx, expected_moves[0].a_dy,
                           expected_moves[0].b_dx, expected_moves[0].b_dy,
                           expected_moves[0].ignored);
                  $display("%0t:   actual   a_dx %0d a_dy %0d b_dx %0d b_dy %0d ign %0b",
                           $time, rsp_data.a_dx, rsp_data.a_dy, rsp_data.b_dx,
                           rsp_data.b_dy, rsp_data.ignored);
                  failures++;
               end
               void'(expected_moves.pop_front());
            end
         end
         rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   task automatic drain();
      while (pending_pairs.size() != 0 || expected_moves.size() != 0 || req_valid)
         @(posedge clock);
      repeat (LATENCY) @(posedge clock);
   endtask

   task automatic write_threshold(logic [cor_pkg::THR_W-1:0] v);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      move_threshold = v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic queue_corners();
      cor_pkg::req_type p;
      for (int m = 0; m < 4; m++) begin
         // extreme shapes: opposite extreme coordinates, widest sizes
         p = '0;
         p.mode = cor_pkg::MODE_W'(m);
         p.a_x = 24'sh7FFFFF; p.a_y = 24'sh800000;
         p.b_x = 24'sh800000; p.b_y = 24'sh7FFFFF;
         p.a_w = '1; p.a_h = '1; p.b_w = '1; p.b_h = '1;
         p.push_a = 1; p.push_b = 1;
         pending_pairs.push_back(p);
         // coincident centres, equal overlaps on both axes
         p = '0;
         p.mode = cor_pkg::MODE_W'(m);
         p.a_w = 23'd512; p.a_h = 23'd512; p.b_w = 23'd512; p.b_h = 23'd512;
         p.push_a = 1; p.push_b = m[0];
         pending_pairs.push_back(p);
         // small overlap that a threshold may drop, and separated shapes
         p.a_x = 24'sd500; p.a_y = -24'sd3; p.push_a = m[1]; p.push_b = 1;
         pending_pairs.push_back(p);
         p.a_x = -24'sd5000; p.a_y = 24'sd4000;
         pending_pairs.push_back(p);
         p = random_pair(0);
         p.mode = cor_pkg::MODE_W'(m);
         pending_pairs.push_back(p);
      end
   endtask

   task automatic run_phase(int count, int idle_pct, int stall_pct);
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      for (int i = 0; i < count; i++)
         pending_pairs.push_back(random_pair($urandom_range(0, 9) < 2 ? 0 :
                                 (1 << $urandom_range(4, 14))));
      drain();
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_ready = 1'b0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      move_threshold = cor_pkg::MIN_MOVE_SQ_RESET;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_sender = 0;
      failures = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      queue_corners();
      drain();
      write_threshold(32'd0);
      queue_corners();
      drain();
      write_threshold(32'hFFFFFFFF);
      run_phase(100, 0, 0);
      write_threshold(32'd65536);
      run_phase(400, 0, 0);

      // hold the sender mid-stream until everything in flight has come back
      for (int i = 0; i < 20; i++) pending_pairs.push_back(random_pair(256));
      while (expected_moves.size() < 8) @(posedge clock);
      hold_sender = 1;
      while (expected_moves.size() != 0) @(posedge clock);
      hold_sender = 0;
      drain();

      write_threshold($urandom);
      run_phase(300, 87, 0);
      write_threshold(32'd1);
      run_phase(300, 0, 87);
      write_threshold(32'd256);
      run_phase(300, 6, 6);
      run_phase(200, 0, 0);

      if (failures == 0) begin
         $display("PASS collision_overlap_resolver_unit");
      end else begin
         $display("FAIL collision_overlap_resolver_unit");
      end
      $finish;
   end

   initial begin
      #4000000;
      $display("FAIL collision_overlap_resolver_unit");
      $finish;
   end

endmodule
